FILE: src/tdu_pkg.sv
// Shared types, codes and helpers for the task dispatch unit.
// Used by tdu_ctrl, tdu_datapath and the top level; depends on nothing.
`default_nettype none
package tdu_pkg;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [15:0] task_id;
    logic [11:0] work_amount;
    logic [7:0]  payload_size;
    logic [0:0]  arrivals_pending;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_task_id;
    logic [1:0]  out_channel;
    logic [1:0]  unit_status;
    logic [0:0]  last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [11:0] work;
    logic [7:0]  size;
  } fifo_entry_t;

  localparam logic [0:0] OpEnqueue = 1'b0;
  localparam logic [0:0] OpTick    = 1'b1;

  localparam logic [1:0] KindResolved = 2'd0;
  localparam logic [1:0] KindSent     = 2'd1;
  localparam logic [1:0] KindStatus   = 2'd2;
  localparam logic [1:0] KindOverflow = 2'd3;

  localparam logic [1:0] CfgExecRate   = 2'd0;
  localparam logic [1:0] CfgChanCount  = 2'd1;
  localparam logic [1:0] CfgChanCaps   = 2'd2;
  localparam logic [1:0] CfgChanQuotas = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic enq;
    logic emit_ovf;
    logic ex_add;
    logic ex_retire;
    logic ex_pop_done;
    logic ex_start;
    logic ex_clr;
    logic ch_next;
    logic ch_add;
    logic ch_fin;
    logic ch_fwd;
    logic ch_clr;
    logic ch_start;
    logic ch_ratio;
    logic sr_init;
    logic sr_cmp;
    logic sr_wr;
    logic emit_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fifo_full;
    logic fifo_empty;
    logic head_ok;
    logic out_free;
    logic ex_valid;
    logic ex_ge;
    logic ex_head_ge;
    logic ch_done;
    logic ch_used;
    logic ct_valid;
    logic ct_ge;
    logic quota_open;
    logic ch_head_ge;
    logic sr_single;
    logic sr_last;
  } sts_t;

  function automatic logic [15:0] lane16(input logic [63:0] v, input logic [1:0] i);
    lane16 = v[16*i +: 16];
  endfunction

endpackage
`default_nettype wire

FILE: src/tdu_ctrl.sv
// Sequencer of the task dispatch unit: takes enqueues, reports overflows and walks
// one tick through execution, channel service, ratio ordering and status. Depends on tdu_pkg.
`default_nettype none
module tdu_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [0:0]    opcode_i,
  output logic               in_stall_o,
  input  wire tdu_pkg::sts_t sts_i,
  output tdu_pkg::cmd_t      cmd_o
);
  import tdu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_OVF, S_EX_ADD, S_EX_CHK, S_EX_LOOP, S_CH_SEL, S_CH_ADD, S_CH_FIN,
    S_CH_LOOP, S_CH_RATIO, S_SR_INIT, S_SR_CMP, S_SR_WR, S_STATUS
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (opcode_i == OpTick) begin
            state_d = S_EX_ADD;
          end else if (sts_i.fifo_full) begin
            state_d = S_OVF;
          end else begin
            cmd_o.enq = 1'b1;
          end
        end
      end
      S_OVF: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ovf = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EX_ADD: begin
        cmd_o.ex_add = 1'b1;
        state_d = S_EX_CHK;
      end
      S_EX_CHK: begin
        if (!sts_i.ex_valid) begin
          state_d = S_EX_LOOP;
        end else if (!sts_i.ex_ge) begin
          state_d = S_CH_SEL;
        end else if (sts_i.out_free) begin
          cmd_o.ex_retire = 1'b1;
          state_d = S_EX_LOOP;
        end
      end
      S_EX_LOOP: begin
        if (sts_i.fifo_empty) begin
          cmd_o.ex_clr = 1'b1;
          state_d = S_CH_SEL;
        end else if (sts_i.head_ok) begin
          if (!sts_i.ex_head_ge) begin
            cmd_o.ex_start = 1'b1;
            state_d = S_CH_SEL;
          end else if (sts_i.out_free) begin
            cmd_o.ex_pop_done = 1'b1;
          end
        end
      end
      S_CH_SEL: begin
        if (sts_i.ch_done) begin
          state_d = S_SR_INIT;
        end else if (!sts_i.ch_used) begin
          cmd_o.ch_next = 1'b1;
        end else begin
          state_d = S_CH_ADD;
        end
      end
      S_CH_ADD: begin
        cmd_o.ch_add = 1'b1;
        state_d = S_CH_FIN;
      end
      S_CH_FIN: begin
        if (!sts_i.ct_valid) begin
          state_d = S_CH_LOOP;
        end else if (!sts_i.ct_ge) begin
          // A task still in flight keeps the channel busy for this tick.
          cmd_o.ch_next = 1'b1;
          state_d = S_CH_SEL;
        end else if (sts_i.out_free) begin
          cmd_o.ch_fin = 1'b1;
          state_d = S_CH_LOOP;
        end
      end
      S_CH_LOOP: begin
        if (sts_i.fifo_empty || !sts_i.quota_open) begin
          cmd_o.ch_clr = 1'b1;
          state_d = S_CH_RATIO;
        end else if (sts_i.head_ok) begin
          if (!sts_i.ch_head_ge) begin
            cmd_o.ch_start = 1'b1;
            state_d = S_CH_RATIO;
          end else if (sts_i.out_free) begin
            cmd_o.ch_fwd = 1'b1;
          end
        end
      end
      S_CH_RATIO: begin
        cmd_o.ch_ratio = 1'b1;
        cmd_o.ch_next = 1'b1;
        state_d = S_CH_SEL;
      end
      S_SR_INIT: begin
        cmd_o.sr_init = 1'b1;
        state_d = sts_i.sr_single ? S_SR_WR : S_SR_CMP;
      end
      S_SR_CMP: begin
        cmd_o.sr_cmp = 1'b1;
        if (sts_i.sr_last) begin
          state_d = S_SR_WR;
        end
      end
      S_SR_WR: begin
        cmd_o.sr_wr = 1'b1;
        state_d = S_STATUS;
      end
      S_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/tdu_datapath.sv
// Datapath of the task dispatch unit: configuration, task queue memory,
// execution and channel state, ratio ranking and the result register. Depends on tdu_pkg.
`default_nettype none
module tdu_datapath #(
  parameter int QUEUE_DEPTH  = 32,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire tdu_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tdu_pkg::out_item_t      out_item_o,
  input  wire tdu_pkg::cmd_t      cmd_i,
  output tdu_pkg::sts_t           sts_o
);
  import tdu_pkg::*;

  localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int CIW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [CIW-1:0] LastB = CIW'(MAX_CHANNELS - 1);
  localparam logic [CIW-1:0] LastA = CIW'((MAX_CHANNELS > 1) ? MAX_CHANNELS - 2 : 0);
  localparam logic [QW-1:0]  LastPtr = QW'(QUEUE_DEPTH - 1);

  // Configuration.
  logic [15:0] exec_rate_q;
  logic [2:0]  chan_count_q;
  logic [63:0] caps_q, quotas_q;

  // Task queue.
  fifo_entry_t         mem_q [QUEUE_DEPTH];
  fifo_entry_t         head_q;
  logic [QW-1:0]       rd_ptr_q, wr_ptr_q;
  logic [CNTW-1:0]     count_q;
  logic                head_ok_q;
  logic                pop;

  // Latched request fields.
  logic [15:0] req_id_q;
  logic        req_pend_q;

  // Execution.
  logic [16:0] ex_prog_q;
  logic [15:0] ex_id_q;
  logic [11:0] ex_work_q;
  logic        ex_valid_q;

  // Channels.
  logic [16:0]    cprog_q  [MAX_CHANNELS];
  logic [16:0]    sent_q   [MAX_CHANNELS];
  logic [15:0]    ct_id_q  [MAX_CHANNELS];
  logic [7:0]     ct_size_q[MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] ct_valid_q;
  logic [16:0]    num_q    [MAX_CHANNELS];
  logic [15:0]    den_q    [MAX_CHANNELS];
  logic [CIW-1:0] order_q  [MAX_CHANNELS];
  logic [CIW-1:0] rank_q   [MAX_CHANNELS];
  logic [2:0]     slot_q;
  logic [CIW-1:0] pa_q, pb_q;

  logic           out_valid_q;
  out_item_t      out_q;

  logic [2:0]     used;
  logic           ch_done;
  logic [CIW-1:0] c;
  logic [1:0]     c2;
  logic [15:0]    cap_c, quota_c;
  logic [32:0]    prod_l, prod_r;
  logic           unsat;
  logic           work_left;

  assign used    = (chan_count_q > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : chan_count_q;
  assign ch_done = (slot_q == 3'(MAX_CHANNELS));
  assign c       = ch_done ? order_q[0] : order_q[slot_q[CIW-1:0]];
  assign c2      = 2'(c);
  assign cap_c   = lane16(caps_q, c2);
  assign quota_c = lane16(quotas_q, c2);
  assign pop     = cmd_i.ex_pop_done || cmd_i.ex_start || cmd_i.ch_fwd || cmd_i.ch_start;

  // Exact ratio compare: a goes before b when num_a*den_b < num_b*den_a,
  // with ties to the lower index, and a is always the lower index here.
  assign prod_l = 33'(num_q[pa_q]) * 33'(den_q[pb_q]);
  assign prod_r = 33'(num_q[pb_q]) * 33'(den_q[pa_q]);

  always_comb begin
    unsat = 1'b0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if ((3'(k) < used) &&
          ((sent_q[k] < {1'b0, lane16(quotas_q, 2'(k))}) || ct_valid_q[k])) begin
        unsat = 1'b1;
      end
    end
  end

  assign work_left = (count_q != '0) || ex_valid_q || req_pend_q;

  always_comb begin
    sts_o            = '0;
    sts_o.fifo_full  = (count_q >= CNTW'(QUEUE_DEPTH));
    sts_o.fifo_empty = (count_q == '0);
    sts_o.head_ok    = head_ok_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
    sts_o.ex_valid   = ex_valid_q;
    sts_o.ex_ge      = (ex_prog_q >= 17'(ex_work_q));
    sts_o.ex_head_ge = (ex_prog_q >= 17'(head_q.work));
    sts_o.ch_done    = ch_done;
    sts_o.ch_used    = (3'(c) < used);
    sts_o.ct_valid   = ct_valid_q[c];
    sts_o.ct_ge      = (cprog_q[c] >= 17'(ct_size_q[c]));
    sts_o.quota_open = (sent_q[c] < 17'(quota_c));
    sts_o.ch_head_ge = (cprog_q[c] >= 17'(head_q.size));
    sts_o.sr_single  = (MAX_CHANNELS == 1);
    sts_o.sr_last    = (pa_q == LastA) && (pb_q == LastB);
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_rate_q  <= '0;
      chan_count_q <= '0;
      caps_q       <= '0;
      quotas_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgExecRate:   exec_rate_q  <= cfg_data_i[15:0];
        CfgChanCount:  chan_count_q <= cfg_data_i[2:0];
        CfgChanCaps:   caps_q       <= cfg_data_i;
        CfgChanQuotas: quotas_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Queue memory: one write port, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.enq) begin
      mem_q[wr_ptr_q] <= '{id: in_item_i.task_id, work: in_item_i.work_amount,
                           size: in_item_i.payload_size};
    end
    head_q <= mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      count_q   <= '0;
      head_ok_q <= 1'b0;
    end else begin
      // head_ok is cleared after a pointer move or a write, until the head register has been read anew.
      head_ok_q <= !(pop || cmd_i.enq);
      if (cmd_i.enq) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
        count_q  <= count_q + 1'b1;
      end else if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
        count_q  <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_id_q <= in_item_i.task_id;
    end
    if (cmd_i.ex_start) begin
      ex_id_q   <= head_q.id;
      ex_work_q <= head_q.work;
    end
    if (cmd_i.ch_start) begin
      ct_id_q[c]   <= head_q.id;
      ct_size_q[c] <= head_q.size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_pend_q <= 1'b0;
      ex_prog_q  <= '0;
      ex_valid_q <= 1'b0;
      ct_valid_q <= '0;
      slot_q     <= '0;
      pa_q       <= '0;
      pb_q       <= '0;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        cprog_q[k] <= '0;
        sent_q[k]  <= '0;
        num_q[k]   <= 17'd1;
        den_q[k]   <= 16'd1;
        order_q[k] <= CIW'(k);
        rank_q[k]  <= '0;
      end
    end else begin
      if (cmd_i.accept) begin
        req_pend_q <= in_item_i.arrivals_pending[0];
        slot_q     <= '0;
      end
      if (cmd_i.ex_add) begin
        ex_prog_q <= ex_prog_q + 17'(exec_rate_q);
      end
      if (cmd_i.ex_retire) begin
        ex_prog_q  <= ex_prog_q - 17'(ex_work_q);
        ex_valid_q <= 1'b0;
      end
      if (cmd_i.ex_pop_done) begin
        ex_prog_q <= ex_prog_q - 17'(head_q.work);
      end
      if (cmd_i.ex_start) begin
        ex_valid_q <= 1'b1;
      end
      if (cmd_i.ex_clr) begin
        ex_prog_q <= '0;
      end
      if (cmd_i.ch_next) begin
        slot_q <= slot_q + 1'b1;
      end
      if (cmd_i.ch_add) begin
        cprog_q[c] <= cprog_q[c] + 17'(cap_c);
      end
      if (cmd_i.ch_fin) begin
        cprog_q[c]    <= cprog_q[c] - 17'(ct_size_q[c]);
        ct_valid_q[c] <= 1'b0;
      end
      if (cmd_i.ch_fwd) begin
        cprog_q[c] <= cprog_q[c] - 17'(head_q.size);
        sent_q[c]  <= sent_q[c] + 17'(head_q.size);
      end
      if (cmd_i.ch_clr) begin
        cprog_q[c] <= '0;
      end
      if (cmd_i.ch_start) begin
        ct_valid_q[c] <= 1'b1;
        sent_q[c]     <= sent_q[c] + 17'(head_q.size);
      end
      if (cmd_i.ch_ratio) begin
        if (quota_c == '0) begin
          num_q[c] <= 17'd1;
          den_q[c] <= 16'd1;
        end else begin
          num_q[c] <= sent_q[c];
          den_q[c] <= quota_c;
        end
      end
      if (cmd_i.sr_init) begin
        for (int k = 0; k < MAX_CHANNELS; k++) begin
          rank_q[k] <= '0;
        end
        pa_q <= '0;
        pb_q <= CIW'((MAX_CHANNELS > 1) ? 1 : 0);
      end
      if (cmd_i.sr_cmp) begin
        // The channel that goes later gains one rank.
        if (prod_l <= prod_r) begin
          rank_q[pb_q] <= rank_q[pb_q] + 1'b1;
        end else begin
          rank_q[pa_q] <= rank_q[pa_q] + 1'b1;
        end
        if (pb_q == LastB) begin
          pa_q <= pa_q + 1'b1;
          pb_q <= pa_q + CIW'(2);
        end else begin
          pb_q <= pb_q + 1'b1;
        end
      end
      if (cmd_i.sr_wr) begin
        for (int k = 0; k < MAX_CHANNELS; k++) begin
          order_q[rank_q[k]] <= CIW'(k);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ovf || cmd_i.ex_retire || cmd_i.ex_pop_done ||
                 cmd_i.ch_fin || cmd_i.ch_fwd || cmd_i.emit_status) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ovf) begin
      out_q <= '{kind: KindOverflow, out_task_id: req_id_q, out_channel: 2'd0,
                 unit_status: 2'd0, last: 1'b1};
    end else if (cmd_i.ex_retire) begin
      out_q <= '{kind: KindResolved, out_task_id: ex_id_q, out_channel: 2'd0,
                 unit_status: 2'd0, last: 1'b0};
    end else if (cmd_i.ex_pop_done) begin
      out_q <= '{kind: KindResolved, out_task_id: head_q.id, out_channel: 2'd0,
                 unit_status: 2'd0, last: 1'b0};
    end else if (cmd_i.ch_fin) begin
      out_q <= '{kind: KindSent, out_task_id: ct_id_q[c], out_channel: c2,
                 unit_status: 2'd0, last: 1'b0};
    end else if (cmd_i.ch_fwd) begin
      out_q <= '{kind: KindSent, out_task_id: head_q.id, out_channel: c2,
                 unit_status: 2'd0, last: 1'b0};
    end else if (cmd_i.emit_status) begin
      out_q <= '{kind: KindStatus, out_task_id: 16'd0, out_channel: 2'd0,
                 unit_status: {work_left, unsat}, last: 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

FILE: src/task_dispatch_unit_step_core.sv
// Top level of the task dispatch unit: joins the sequencer and the datapath.
// Depends on tdu_pkg, tdu_ctrl and tdu_datapath.
//
// One request at a time. An enqueue does not stall the input. An overflow
// request moves the sequencer to S_OVF, which loads the overflow result into
// the result register once that register is free. After a tick is taken, the
// input stays stalled while the sequencer walks execution, every channel slot
// and the pairwise ratio ranking and emits the status result, plus any output
// stalls. Each queue pop of a retired or forwarded task waits for a head
// memory read. A channel whose task is still in flight skips its queue service
// and ratio update. The single head read of the queue memory and the one ratio
// comparator set the length of this stall. The result register lets the next
// request enter while the last result is still waiting.
`default_nettype none
module task_dispatch_unit_step_core #(
  parameter int QUEUE_DEPTH  = 32,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tdu_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tdu_pkg::out_item_t      out_item_o
);
  import tdu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tdu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_item_i.opcode),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tdu_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire
